// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ERQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked check that also runs through reset.
`define ERQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/erq_pkg.sv =====
// Shared widths, register codes and types for the Euclidean step query block.
package erq_pkg;

  localparam int unsigned LenW     = 7;
  localparam int unsigned PulseW   = 7;
  localparam int unsigned RotW     = 6;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned PosW     = 6;
  localparam int unsigned ProdW    = 2 * LenW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  localparam int unsigned MaxStepsDefault = 64;
  localparam int unsigned PipeDepth       = 7;

  localparam logic [CfgIdxW-1:0] CfgLength   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPulses   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRotation = 2'd2;

  localparam logic [LenW-1:0]   LenReset    = 7'd16;
  localparam logic [PulseW-1:0] PulseReset  = 7'd4;
  localparam logic [RotW-1:0]   RotReset    = 6'd0;

  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [PulseW-1:0] pulses;
    logic [RotW-1:0]   rot;
    logic              len_zero;
    logic              all_pulses;
  } cfg_t;

endpackage

// ===== hw/rtl/erq_if.sv =====
// Valid/ready channel interfaces for step queries and pulse results.
interface erq_in_if;
  import erq_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] step_index;

  modport source (output valid, output step_index, input ready);
  modport sink   (input valid, input step_index, output ready);
endinterface

interface erq_out_if;
  import erq_pkg::*;
  logic            valid;
  logic            ready;
  logic            pulse;
  logic [PosW-1:0] position;

  modport source (output valid, output pulse, output position, input ready);
  modport sink   (input valid, input pulse, input position, output ready);
endinterface

// ===== hw/rtl/erq_rem_steps.sv =====
// A few restoring remainder steps: shifts dividend bits in, MSB first.
module erq_rem_steps #(
  parameter int unsigned STEPS = 4
) (
  input  logic [erq_pkg::LenW-1:0] rem_i,
  input  logic [STEPS-1:0]         bits_i,
  input  logic [erq_pkg::LenW-1:0] div_i,
  output logic [erq_pkg::LenW-1:0] rem_o
);
  import erq_pkg::*;

  always_comb begin
    logic [LenW:0]   acc;
    logic [LenW-1:0] r;
    r   = rem_i;
    acc = '0;
    for (int k = STEPS - 1; k >= 0; k--) begin
      acc = {r, bits_i[k]};
      if (acc >= {1'b0, div_i}) begin
        acc = acc - {1'b0, div_i};
      end
      r = acc[LenW-1:0];
    end
    rem_o = r;
  end

endmodule

// ===== hw/rtl/erq_cfg.sv =====
// Configuration registers and the derived effective length and flags.
module erq_cfg #(
  parameter int unsigned MAX_STEPS = erq_pkg::MaxStepsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [erq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [erq_pkg::CfgDataW-1:0] cfg_wdata_i,
  output erq_pkg::cfg_t               cfg_o
);
  import erq_pkg::*;

  localparam logic [LenW:0] MaxW = (LenW + 1)'(MAX_STEPS);

  logic [LenW-1:0]   len_q;
  logic [PulseW-1:0] pulses_q;
  logic [RotW-1:0]   rot_q;
  logic [LenW-1:0]   len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LenReset;
      pulses_q <= PulseReset;
      rot_q    <= RotReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLength:   len_q    <= cfg_wdata_i[LenW-1:0];
        CfgPulses:   pulses_q <= cfg_wdata_i[PulseW-1:0];
        CfgRotation: rot_q    <= cfg_wdata_i[RotW-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = ({1'b0, len_q} > MaxW) ? MaxW[LenW-1:0] : len_q;

  assign cfg_o.len        = len_eff;
  assign cfg_o.pulses     = pulses_q;
  assign cfg_o.rot        = rot_q;
  assign cfg_o.len_zero   = (len_eff == '0);
  assign cfg_o.all_pulses = (pulses_q >= len_eff);

endmodule

// ===== hw/rtl/euclidean_rhythm_step_query.sv =====
// Top level: seven-stage pipeline answering Euclidean rhythm step queries.
//
//  channel   dir  handshake      word
//  step_i    in   valid/ready    step_index[7:0]
//  result_o  out  valid/ready    pulse, position[5:0]
//  cfg       in   cfg_we_i       cfg_idx_i[1:0], cfg_wdata_i[6:0]
//
// One word accepted per cycle while the output is not stalled.
// Stages: index/rotation remainder (2), fill offset, multiply, product
// remainder (2), pulse decision into the output register.
// The whole pipe advances together; a stalled output freezes every stage.
// Reset clears the valid bits and loads the register defaults.
module euclidean_rhythm_step_query #(
  parameter int unsigned MAX_STEPS = erq_pkg::MaxStepsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  erq_in_if.sink                       step_i,
  erq_out_if.source                    result_o,
  input  logic                         cfg_we_i,
  input  logic [erq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [erq_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import erq_pkg::*;

  localparam int unsigned IdxHiW = IdxW / 2;
  localparam int unsigned IdxLoW = IdxW - IdxHiW;
  localparam int unsigned RotHiW = RotW / 2;
  localparam int unsigned RotLoW = RotW - RotHiW;

  cfg_t cfg;
  logic adv;

  erq_cfg #(.MAX_STEPS(MAX_STEPS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic [PipeDepth-1:0] v_q;

  assign adv          = !v_q[PipeDepth-1] || result_o.ready;
  assign step_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[PipeDepth-2:0], step_i.valid};
    end
  end

  // stage 1: upper halves of index and rotation remainders
  logic [LenW-1:0]   s1_ri_d, s1_rr_d;
  logic [LenW-1:0]   s1_ri_q, s1_rr_q;
  logic [IdxLoW-1:0] s1_idx_lo_q;
  logic [RotLoW-1:0] s1_rot_lo_q;

  erq_rem_steps #(.STEPS(IdxHiW)) u_idx_hi (
    .rem_i  ('0),
    .bits_i (step_i.step_index[IdxW-1:IdxLoW]),
    .div_i  (cfg.len),
    .rem_o  (s1_ri_d)
  );

  erq_rem_steps #(.STEPS(RotHiW)) u_rot_hi (
    .rem_i  ('0),
    .bits_i (cfg.rot[RotW-1:RotLoW]),
    .div_i  (cfg.len),
    .rem_o  (s1_rr_d)
  );

  // stage 2: lower halves give position and reduced rotation
  logic [LenW-1:0] s2_pos_d, s2_off_d;
  logic [LenW-1:0] s2_pos_q, s2_off_q;

  erq_rem_steps #(.STEPS(IdxLoW)) u_idx_lo (
    .rem_i  (s1_ri_q),
    .bits_i (s1_idx_lo_q),
    .div_i  (cfg.len),
    .rem_o  (s2_pos_d)
  );

  erq_rem_steps #(.STEPS(RotLoW)) u_rot_lo (
    .rem_i  (s1_rr_q),
    .bits_i (s1_rot_lo_q),
    .div_i  (cfg.len),
    .rem_o  (s2_off_d)
  );

  // stage 3: fill number counted backwards from the start position
  logic [LenW-1:0] s3_start, s3_fill_d;
  logic [LenW-1:0] s3_pos_q, s3_fill_q;

  assign s3_start  = (s2_off_q == '0) ? cfg.len - LenW'(1) : s2_off_q - LenW'(1);
  assign s3_fill_d = (s3_start >= s2_pos_q) ? s3_start - s2_pos_q
                                            : s3_start + (cfg.len - s2_pos_q);

  // stage 4: bucket product
  logic [ProdW-1:0] s4_prod_q;
  logic [LenW-1:0]  s4_pos_q;

  // stages 5 and 6: product remainder, LenW bits each
  logic [LenW-1:0] s5_rem_d, s5_rem_q, s5_pos_q, s5_lo_q;
  logic [LenW-1:0] s6_rem_d, s6_rem_q, s6_pos_q;

  erq_rem_steps #(.STEPS(LenW)) u_prod_hi (
    .rem_i  ('0),
    .bits_i (s4_prod_q[ProdW-1:LenW]),
    .div_i  (cfg.len),
    .rem_o  (s5_rem_d)
  );

  erq_rem_steps #(.STEPS(LenW)) u_prod_lo (
    .rem_i  (s5_rem_q),
    .bits_i (s5_lo_q),
    .div_i  (cfg.len),
    .rem_o  (s6_rem_d)
  );

  // stage 7: pulse decision into the output register
  logic            out_pulse_d, out_pulse_q;
  logic [PosW-1:0] out_pos_d, out_pos_q;

  always_comb begin
    if (cfg.len_zero) begin
      out_pulse_d = 1'b0;
    end else if (cfg.all_pulses) begin
      out_pulse_d = 1'b1;
    end else begin
      out_pulse_d = (({1'b0, s6_rem_q} + {1'b0, cfg.pulses}) >= {1'b0, cfg.len});
    end
    out_pos_d = cfg.len_zero ? '0 : s6_pos_q[PosW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ri_q     <= s1_ri_d;
      s1_rr_q     <= s1_rr_d;
      s1_idx_lo_q <= step_i.step_index[IdxLoW-1:0];
      s1_rot_lo_q <= cfg.rot[RotLoW-1:0];
      s2_pos_q    <= s2_pos_d;
      s2_off_q    <= s2_off_d;
      s3_pos_q    <= s2_pos_q;
      s3_fill_q   <= s3_fill_d;
      s4_pos_q    <= s3_pos_q;
      s4_prod_q   <= ProdW'(s3_fill_q) * ProdW'(cfg.pulses);
      s5_pos_q    <= s4_pos_q;
      s5_rem_q    <= s5_rem_d;
      s5_lo_q     <= s4_prod_q[LenW-1:0];
      s6_pos_q    <= s5_pos_q;
      s6_rem_q    <= s6_rem_d;
      out_pulse_q <= out_pulse_d;
      out_pos_q   <= out_pos_d;
    end
  end

  assign result_o.valid    = v_q[PipeDepth-1];
  assign result_o.pulse    = out_pulse_q;
  assign result_o.position = out_pos_q;

endmodule

// ===== hw/rtl/erq_checker.sv =====
// Port-level checks for the step query block, bound to the top level.
`include "assert_macros.svh"

module erq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        step_valid,
  input logic                        step_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        res_pulse,
  input logic [erq_pkg::PosW-1:0]    res_position
);
  import erq_pkg::*;

  localparam int unsigned CntW = $clog2(PipeDepth + 1);

  logic            in_acc, out_acc;
  logic [CntW-1:0] cnt_q;

  assign in_acc  = step_valid && step_ready;
  assign out_acc = res_valid && res_ready;

  // words in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  `ERQ_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_pulse) && $stable(res_position), "result word changed while stalled")
  `ERQ_ASSERT(a_ready_stall, !step_ready |-> res_valid && !res_ready, "input refused without an output stall")
  `ERQ_ASSERT_RST(a_reset_empty, !$past(rst_ni) |-> !res_valid, "result valid straight after reset")
  `ERQ_ASSERT(a_no_invent, res_valid |-> cnt_q != '0, "result without a pending query")
  `ERQ_ASSERT(a_depth, cnt_q <= CntW'(PipeDepth), "more words in flight than stages")

endmodule

bind euclidean_rhythm_step_query erq_checker u_erq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .step_valid   (step_i.valid),
  .step_ready   (step_i.ready),
  .res_valid    (result_o.valid),
  .res_ready    (result_o.ready),
  .res_pulse    (result_o.pulse),
  .res_position (result_o.position)
);
